// ----- rtl/smpf_pkg.sv -----
// ----------------------------------------------------------------------------
// smpf_pkg
// Shared types and constants for the smallest prime factor factorizer.
// ----------------------------------------------------------------------------
package smpf_pkg;

    localparam int VALUE_W        = 16;
    localparam int TABLE_SIZE_DEF = 65536;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS);
    localparam int DIV_CNT_W      = $clog2(VALUE_W);
    localparam int MIN_PRIME      = 2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_SV_RD_I,
        ST_SV_CHK_I,
        ST_SV_RD_J,
        ST_SV_CHK_J,
        ST_SV_NEXT,
        ST_IDLE,
        ST_Q_RD,
        ST_Q_CHK,
        ST_DIV,
        ST_DIV_END,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/smallest_prime_factor_factorizer.sv -----
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer
// Factors 16-bit values with a sieve-built smallest prime factor table.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_value carries one request per value to
// factor. The result channel m_valid/m_ready carries the prime factors in
// ascending order with repetition; m_is_last marks the final one. Values 0,
// 1 and values not below TABLE_SIZE give one result with m_no_factors set
// and m_factor zero.
// After reset the table (min(TABLE_SIZE, 65536) entries) is first written
// with its own index, one entry per cycle, then sieved: through the single
// table read port, each candidate below the square root is read and checked,
// and each multiple visited is read and, if still unmarked, written. s_ready
// stays low until it is done.
// A request for a value without factors goes straight to the output load;
// otherwise each factor takes a table read, a restoring divide and the
// output load. s_ready is high only while no request is in work. A stalled
// receiver holds the result in the output register and the sequencer waits
// for it to drain before loading the next factor.
// ----------------------------------------------------------------------------
module smallest_prime_factor_factorizer
    import smpf_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_factor,
    output logic               m_is_last,
    output logic               m_no_factors
);

    localparam int unsigned FULL = 1 << VALUE_W;
    localparam int unsigned D    = (TABLE_SIZE < FULL) ? TABLE_SIZE : FULL;
    localparam int          AW   = $clog2(D);
    localparam int          CW   = AW + 1;
    localparam logic [VALUE_W:0] LIMIT   = (VALUE_W + 1)'(D);
    localparam logic [CW-1:0]    D_C     = CW'(D);
    localparam logic [AW-1:0]    LAST_A  = AW'(D - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]        i_reg, i_next;
    logic [CW-1:0]        sq_reg, sq_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [VALUE_W-1:0]   v_reg, v_next;
    logic [VALUE_W-1:0]   fac_reg, fac_next;
    logic [VALUE_W-1:0]   rest_reg, rest_next;
    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic                 none_reg, none_next;

    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_factor_reg, m_factor_next;
    logic               m_is_last_reg, m_is_last_next;
    logic               m_no_factors_reg, m_no_factors_next;

    logic [VALUE_W-1:0] mem [D];
    logic [VALUE_W-1:0] mem_rdata;
    logic [AW-1:0]      mem_raddr;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_we;

    logic [CW-1:0]    j_sum;
    logic [CW-1:0]    sq_sum;
    logic             prime_hit;
    logic             mark_hit;
    logic             trivial;
    logic             f_bad;
    logic [VALUE_W:0] trial;
    logic             trial_ge;
    logic [VALUE_W:0] trial_diff;
    logic             slot_free;
    logic             emit_last;

    // table memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    assign j_sum      = j_reg + CW'(i_reg);
    assign sq_sum     = sq_reg + {i_reg, 1'b1};
    assign prime_hit  = (mem_rdata == VALUE_W'(i_reg));
    assign mark_hit   = (mem_rdata == VALUE_W'(j_reg[AW-1:0]));
    assign trivial    = (s_value < VALUE_W'(MIN_PRIME)) || ({1'b0, s_value} >= LIMIT);
    assign f_bad      = (mem_rdata < VALUE_W'(MIN_PRIME)) || (mem_rdata > v_reg);
    assign trial      = {rem_reg, quo_reg[VALUE_W-1]};
    assign trial_ge   = (trial >= {1'b0, fac_reg});
    assign trial_diff = trial - {1'b0, fac_reg};
    assign slot_free  = !m_valid_reg || m_ready;
    assign emit_last  = none_reg || (rest_reg == VALUE_W'(1))
                        || (n_reg == RES_CNT_W'(MAX_RESULTS - 1));

    always_comb begin
        unique case (state_reg)
            ST_SV_RD_I: mem_raddr = i_reg;
            ST_SV_RD_J: mem_raddr = j_reg[AW-1:0];
            default:    mem_raddr = v_reg[AW-1:0];
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (j_reg[AW-1:0] == LAST_A) begin
                    state_next = ST_SV_RD_I;
                end
            end
            ST_SV_RD_I:  state_next = ST_SV_CHK_I;
            ST_SV_CHK_I: state_next = prime_hit ? ST_SV_RD_J : ST_SV_NEXT;
            ST_SV_RD_J:  state_next = ST_SV_CHK_J;
            ST_SV_CHK_J: state_next = (j_sum >= D_C) ? ST_SV_NEXT : ST_SV_RD_J;
            ST_SV_NEXT:  state_next = (sq_sum >= D_C) ? ST_IDLE : ST_SV_RD_I;
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = trivial ? ST_EMIT : ST_Q_RD;
                end
            end
            ST_Q_RD:  state_next = ST_Q_CHK;
            ST_Q_CHK: state_next = f_bad ? ST_EMIT : ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == DIV_CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: state_next = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = emit_last ? ST_IDLE : ST_Q_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        i_next            = i_reg;
        sq_next           = sq_reg;
        j_next            = j_reg;
        v_next            = v_reg;
        fac_next          = fac_reg;
        rest_next         = rest_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        dcnt_next         = dcnt_reg;
        n_next            = n_reg;
        none_next         = none_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_factor_next     = m_factor_reg;
        m_is_last_next    = m_is_last_reg;
        m_no_factors_next = m_no_factors_reg;
        mem_we            = 1'b0;
        mem_waddr         = j_reg[AW-1:0];
        mem_wdata         = VALUE_W'(j_reg[AW-1:0]);

        unique case (state_reg)
            ST_INIT: begin
                mem_we = 1'b1;
                j_next = (j_reg[AW-1:0] == LAST_A) ? '0 : j_reg + CW'(1);
            end
            ST_SV_CHK_I: begin
                j_next = sq_reg;
            end
            ST_SV_CHK_J: begin
                mem_we    = mark_hit;
                mem_wdata = VALUE_W'(i_reg);
                j_next    = j_sum;
            end
            ST_SV_NEXT: begin
                i_next  = i_reg + AW'(1);
                sq_next = sq_sum;
            end
            ST_IDLE: begin
                v_next    = s_value;
                n_next    = '0;
                none_next = trivial;
                fac_next  = '0;
                rest_next = VALUE_W'(1);
            end
            ST_Q_CHK: begin
                fac_next  = f_bad ? v_reg : mem_rdata;
                rest_next = VALUE_W'(1);
                quo_next  = v_reg;
                rem_next  = '0;
                dcnt_next = '0;
            end
            ST_DIV: begin
                rem_next  = trial_ge ? trial_diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
                quo_next  = {quo_reg[VALUE_W-2:0], trial_ge};
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
            end
            ST_DIV_END: begin
                // a table entry that does not divide means the rest is prime
                if (rem_reg != '0) begin
                    fac_next  = v_reg;
                    rest_next = VALUE_W'(1);
                end else begin
                    rest_next = quo_reg;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next      = 1'b1;
                    m_factor_next     = fac_reg;
                    m_is_last_next    = emit_last;
                    m_no_factors_next = none_reg;
                    v_next            = rest_reg;
                    n_next            = n_reg + RES_CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            i_reg       <= AW'(MIN_PRIME);
            sq_reg      <= CW'(MIN_PRIME * MIN_PRIME);
            j_reg       <= '0;
            n_reg       <= '0;
            dcnt_reg    <= '0;
            none_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            sq_reg      <= sq_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            dcnt_reg    <= dcnt_next;
            none_reg    <= none_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg            <= v_next;
        fac_reg          <= fac_next;
        rest_reg         <= rest_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        m_factor_reg     <= m_factor_next;
        m_is_last_reg    <= m_is_last_next;
        m_no_factors_reg <= m_no_factors_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_factor     = m_factor_reg;
    assign m_is_last    = m_is_last_reg;
    assign m_no_factors = m_no_factors_reg;

endmodule

// ----- rtl/smpf_checker.sv -----
// ----------------------------------------------------------------------------
// smpf_checker
// Port-level checks for the smallest prime factor factorizer.
// ----------------------------------------------------------------------------
module smpf_checker
    import smpf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [VALUE_W-1:0] s_value,
    input logic               m_valid,
    input logic               m_ready,
    input logic [VALUE_W-1:0] m_factor,
    input logic               m_is_last,
    input logic               m_no_factors
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_factor) && $stable(m_is_last)
                                && $stable(m_no_factors))
        else $error("stalled result changed");

    // no-factor result is a lone zero
    a_none_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_factors |-> m_is_last && (m_factor == '0))
        else $error("no-factor result malformed");

    // real factors are at least two
    a_factor_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_no_factors |-> (m_factor >= VALUE_W'(MIN_PRIME)))
        else $error("factor below two");

    // busy after a request is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after a request");

endmodule

bind smallest_prime_factor_factorizer smpf_checker u_smpf_checker (.*);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer testbench
// Waits out the sieve fill that follows reset, then sends requests to
// factor and checks every returned factor, in order, against a local
// smallest-factor table that the bench builds itself.
// ----------------------------------------------------------------------------
module testbench;
    import smpf_pkg::*;

    localparam longint RUN_LIMIT = 64'd50_000_000;
    localparam int unsigned SMALL_PRIMES [6] = '{2, 3, 5, 7, 11, 13};

    typedef struct packed {
        logic [VALUE_W-1:0] factor;
        logic               is_last;
        logic               no_factors;
    } factor_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [VALUE_W-1:0] m_factor;
    logic               m_is_last;
    logic               m_no_factors;

    int unsigned    least_factor [TABLE_SIZE_DEF];
    factor_result_t pending_factors [$];
    int             error_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             hold_len = 0;
    int             hold_go = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    smallest_prime_factor_factorizer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_factor    (m_factor),
        .m_is_last   (m_is_last),
        .m_no_factors(m_no_factors)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void build_factor_table();
        int unsigned i;
        int unsigned j;
        for (i = 0; i < TABLE_SIZE_DEF; i++)
            least_factor[i] = i;
        for (i = MIN_PRIME; i * i < TABLE_SIZE_DEF; i++) begin
            if (least_factor[i] == i) begin
                for (j = i * i; j < TABLE_SIZE_DEF; j += i)
                    if (least_factor[j] == j)
                        least_factor[j] = i;
            end
        end
    endfunction

    function automatic void predict_factors(input logic [VALUE_W-1:0] value);
        factor_result_t r;
        int unsigned    rest;
        int unsigned    f;
        int             n;
        rest = value;
        n = 0;
        if (rest < MIN_PRIME || rest >= TABLE_SIZE_DEF) begin
            r.factor = '0;
            r.is_last = 1'b1;
            r.no_factors = 1'b1;
            pending_factors = {pending_factors, r};
            return;
        end
        while (rest != 1 && n < MAX_RESULTS) begin
            f = least_factor[rest];
            if (f < MIN_PRIME || f > rest || (rest % f) != 0)
                f = rest;
            r.factor = f[VALUE_W-1:0];
            r.is_last = (rest / f == 1) || (n == MAX_RESULTS - 1);
            r.no_factors = 1'b0;
            pending_factors = {pending_factors, r};
            rest = rest / f;
            n++;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned v;
        int unsigned p;
        v = 1;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(16'hFFFF);
            4: v = $urandom_range(15);
            5, 6: begin
                repeat ($urandom_range(1, 15)) begin
                    p = SMALL_PRIMES[$urandom_range(5)];
                    if (v * p < TABLE_SIZE_DEF)
                        v = v * p;
                end
            end
            7: v = (1 << $urandom_range(15)) * $urandom_range(1, 3);
            8: v = 16'hFFFF - $urandom_range(255);
            default: begin
                p = $urandom_range(2, 255);
                v = p * p;
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    task automatic send_request(input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_factors(value);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_factors.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    task automatic test_no_factor_values();
        send_request(16'd0);
        send_request(16'd1);
        send_request(16'd0);
        send_request(16'd1);
    endtask

    task automatic test_extreme_values();
        send_request(16'd2);
        send_request(16'd3);
        send_request(16'd4);
        send_request(16'hFFFF);
        send_request(16'hFFFE);
        send_request(16'd65521);
        send_request(16'h8000);
        send_request(16'hC000);
        send_request(16'd63001);
        send_request(16'd65025);
        send_request(16'd30030);
        send_request(16'd59049);
        send_request(16'h5555);
        send_request(16'hAAAA);
        send_request(16'd255);
        send_request(16'd256);
        send_request(16'd257);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_request(random_value());
    endtask

    task automatic test_output_stall();
        hold_len <= 400;
        hold_go <= hold_go + 1;
        send_request(16'h8000);
        send_request(16'd30030);
        send_request(16'd59049);
        send_request(16'd1);
        send_request(16'd65025);
        send_request(random_value());
    endtask

    task automatic test_sender_pause();
        send_request(16'd49152);
        send_request(random_value());
        wait_all_results();
        send_request(16'd0);
        send_request(random_value());
    endtask

    // result channel: random stalls plus requested long hold-offs
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        factor_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_factors.size() == 0) begin
                $error("unexpected result: factor %0d is_last %0b no_factors %0b",
                       m_factor, m_is_last, m_no_factors);
                error_count++;
            end else begin
                want = pending_factors.pop_front();
                if (m_factor !== want.factor) begin
                    $error("m_factor: expected %0d, got %0d", want.factor, m_factor);
                    error_count++;
                end
                if (m_is_last !== want.is_last) begin
                    $error("m_is_last: expected %0b, got %0b", want.is_last, m_is_last);
                    error_count++;
                end
                if (m_no_factors !== want.no_factors) begin
                    $error("m_no_factors: expected %0b, got %0b",
                           want.no_factors, m_no_factors);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("smallest_prime_factor_factorizer regression: fail");
        $finish;
    end

    initial begin
        build_factor_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(18, 79);
        test_no_factor_values();
        test_extreme_values();
        test_random_mix(30);

        set_idling(79, 18);
        test_random_mix(30);
        test_output_stall();

        set_idling(0, 0);
        test_sender_pause();
        test_random_mix(30);

        wait_all_results();
        repeat (50) @(posedge aclk);
        if (pending_factors.size() != 0) begin
            $error("%0d results never arrived", pending_factors.size());
            error_count++;
        end
        if (error_count == 0)
            $display("smallest_prime_factor_factorizer regression: pass");
        else
            $display("smallest_prime_factor_factorizer regression: fail");
        $finish;
    end

endmodule
